[src/pftm_pkg.sv]
package pftm_pkg;

    // Field and register widths.
    localparam int TPS_W       = 32;
    localparam int RPM_W       = 16;
    localparam int START_W     = 7;
    localparam int PPR_W       = 4;
    localparam int DUTY_W      = 8;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;
    localparam int M_PAD_W     = M_TDATA_W - DUTY_W - RPM_W - 1;

    // Arithmetic constants.
    localparam logic [6:0] PCT_SCALE   = 7'd100;
    localparam logic [6:0] START_LIMIT = 7'd100;
    localparam logic [5:0] SEC_PER_MIN = 6'd60;

    // Quotient bits resolved by the serial divider for duty and speed.
    localparam int DUTY_QBITS = 9;
    localparam int SPD_QBITS  = 16;
    // Width of ticks_per_second * 60 and of rpm * pulses * 2.
    localparam int HALF_NUM_W = TPS_W + 6;
    localparam int HALF_DEN_W = RPM_W + PPR_W + 1;
    localparam int SPD_PROD_W = RPM_W + DUTY_W;

    // Configuration register indexes.
    localparam logic [1:0] REG_TPS   = 2'd0;
    localparam logic [1:0] REG_MAX   = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;
    localparam logic [1:0] REG_PPR   = 2'd3;

    // Register reset values.
    localparam logic [TPS_W-1:0]   TPS_RESET   = 32'd1000000;
    localparam logic [RPM_W-1:0]   MAX_RESET   = 16'd8000;
    localparam logic [START_W-1:0] START_RESET = 7'd20;
    localparam logic [PPR_W-1:0]   PPR_RESET   = 4'd2;

    typedef struct packed {
        logic [TPS_W-1:0]   tps;
        logic [RPM_W-1:0]   max_rpm;
        logic [START_W-1:0] start_duty;
        logic [PPR_W-1:0]   ppr;
    } pftm_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPD_PRE,
        ST_LOAD,
        ST_CHECK,
        ST_RUN,
        ST_FINISH,
        ST_TACH_PRE,
        ST_OUT
    } pftm_state_t;

    typedef enum logic [1:0] {
        OP_DUTY,
        OP_SPEED,
        OP_HALF
    } pftm_op_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        logic     step;
        logic     finish;
        logic     ovf;
        pftm_op_t op;
        logic     spd_zero;
        logic     spd_max;
        logic     tach_clear;
        logic     out_load;
    } pftm_cmd_t;

    typedef struct packed {
        logic pre_ovf;
        logic last_step;
        logic duty_lt_start;
        logic start_ge_100;
        logic tach_stop;
    } pftm_status_t;

endpackage

[src/pftm_ctrl.sv]
module pftm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_kind,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  pftm_pkg::pftm_status_t status,
    output pftm_pkg::pftm_cmd_t    cmd
);
    import pftm_pkg::*;

    pftm_state_t state_reg, state_next;
    pftm_op_t    op_reg, op_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // Where the sequence goes once a division has been applied.
    function automatic pftm_state_t state_after(pftm_op_t op);
        case (op)
            OP_SPEED: return ST_TACH_PRE;
            default:  return ST_OUT;
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_DUTY;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.op        = op_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (s_kind) begin
                        op_next    = OP_DUTY;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_SPD_PRE;
                    end
                end
            end
            ST_SPD_PRE: begin
                if (status.duty_lt_start) begin
                    cmd.spd_zero = 1'b1;
                    state_next   = ST_TACH_PRE;
                end else if (status.start_ge_100) begin
                    cmd.spd_max = 1'b1;
                    state_next  = ST_TACH_PRE;
                end else begin
                    op_next    = OP_SPEED;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.pre_ovf) begin
                    cmd.finish = 1'b1;
                    cmd.ovf    = 1'b1;
                    state_next = state_after(op_reg);
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (status.last_step) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = state_after(op_reg);
            end
            ST_TACH_PRE: begin
                if (status.tach_stop) begin
                    cmd.tach_clear = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    op_next    = OP_HALF;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[src/pftm_dp.sv]
module pftm_dp #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_kind,
    input  logic                          in_level,
    input  pftm_pkg::pftm_cfg_t           cfg,
    input  pftm_pkg::pftm_cmd_t           cmd,
    output pftm_pkg::pftm_status_t        status,
    output logic                          out_tach,
    output logic [pftm_pkg::RPM_W-1:0]    out_rpm,
    output logic [pftm_pkg::DUTY_W-1:0]   out_duty
);
    import pftm_pkg::*;

    localparam int CW      = COUNT_WIDTH;
    localparam int DUTY_PW = CW + 7;
    // Quotient bits for the half period; a wider quotient never fits the counter.
    localparam int HB      = (CW < HALF_NUM_W) ? CW : HALF_NUM_W;
    localparam int SW      = (HB > SPD_QBITS) ? HB : SPD_QBITS;
    localparam int RW_A    = (CW > HALF_DEN_W) ? CW : HALF_DEN_W;
    localparam int RW      = (RW_A > HALF_NUM_W - HB) ? RW_A : HALF_NUM_W - HB;
    localparam int CNTW    = $clog2(SW + 1);
    localparam int CMPW    = (CW > SW) ? CW : SW;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic                  pwm_prev_reg, pwm_prev_next;
    logic [CW-1:0]         ticks_reg, ticks_next;
    logic [CW-1:0]         period_reg, period_next;
    logic [CW-1:0]         high_reg, high_next;
    logic [CW-1:0]         tach_cnt_reg, tach_cnt_next;
    logic [RPM_W-1:0]      rpm_reg, rpm_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    logic                  tach_out_reg, tach_out_next;

    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         den_reg, den_next;
    logic [SW-1:0]         num_reg, num_next;
    logic [SW-1:0]         quo_reg, quo_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;

    logic                  out_tach_reg, out_tach_next;
    logic [RPM_W-1:0]      out_rpm_reg, out_rpm_next;
    logic [DUTY_W-1:0]     out_duty_reg, out_duty_next;

    logic [DUTY_PW-1:0]    duty_prod;
    logic [DUTY_W-1:0]     spd_diff;
    logic [SPD_PROD_W-1:0] spd_prod;
    logic [HALF_NUM_W-1:0] half_num;
    logic [HALF_DEN_W-1:0] half_den;
    logic [RW:0]           trial;
    logic [RW:0]           trial_diff;
    logic                  fits;
    logic [CW-1:0]         ticks_inc;
    logic [CW-1:0]         tach_inc;
    logic [SW-1:0]         quo_half;
    logic                  half_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_prev_reg <= 1'b0;
            ticks_reg    <= '0;
            period_reg   <= '0;
            high_reg     <= '0;
            tach_cnt_reg <= '0;
            rpm_reg      <= '0;
            duty_reg     <= '0;
            tach_out_reg <= 1'b0;
        end else begin
            pwm_prev_reg <= pwm_prev_next;
            ticks_reg    <= ticks_next;
            period_reg   <= period_next;
            high_reg     <= high_next;
            tach_cnt_reg <= tach_cnt_next;
            rpm_reg      <= rpm_next;
            duty_reg     <= duty_next;
            tach_out_reg <= tach_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        out_tach_reg <= out_tach_next;
        out_rpm_reg  <= out_rpm_next;
        out_duty_reg <= out_duty_next;
    end

    always_comb begin
        duty_prod  = DUTY_PW'(high_reg) * DUTY_PW'(PCT_SCALE);
        spd_diff   = duty_reg - DUTY_W'(cfg.start_duty);
        spd_prod   = SPD_PROD_W'(cfg.max_rpm) * SPD_PROD_W'(spd_diff);
        half_num   = HALF_NUM_W'(cfg.tps) * HALF_NUM_W'(SEC_PER_MIN);
        half_den   = (HALF_DEN_W'(rpm_reg) * HALF_DEN_W'(cfg.ppr)) << 1;

        // One restoring step: bring down the next dividend bit and try to subtract.
        trial      = {rem_reg, num_reg[SW-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = trial >= {1'b0, den_reg};

        ticks_inc  = (ticks_reg == CNT_MAX) ? ticks_reg : ticks_reg + 1'b1;
        tach_inc   = (tach_cnt_reg == CNT_MAX) ? tach_cnt_reg : tach_cnt_reg + 1'b1;
        quo_half   = (quo_reg == '0) ? SW'(1) : quo_reg;
        half_hit   = CMPW'(tach_inc) >= CMPW'(quo_half);

        pwm_prev_next = pwm_prev_reg;
        ticks_next    = ticks_reg;
        period_next   = period_reg;
        high_next     = high_reg;
        tach_cnt_next = tach_cnt_reg;
        rpm_next      = rpm_reg;
        duty_next     = duty_reg;
        tach_out_next = tach_out_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        out_tach_next = out_tach_reg;
        out_rpm_next  = out_rpm_reg;
        out_duty_next = out_duty_reg;

        if (cmd.accept) begin
            if (in_kind) begin
                if (in_level && !pwm_prev_reg) begin
                    if (ticks_reg != '0) begin
                        period_next = ticks_reg;
                    end
                    ticks_next = '0;
                end else if (!in_level && pwm_prev_reg) begin
                    high_next = ticks_reg;
                end
                pwm_prev_next = in_level;
            end else begin
                ticks_next = ticks_inc;
            end
        end

        if (cmd.load) begin
            quo_next = '0;
            case (cmd.op)
                OP_DUTY: begin
                    rem_next = RW'(duty_prod >> DUTY_QBITS);
                    den_next = RW'(period_reg);
                    num_next = SW'({{SW{1'b0}}, duty_prod} << (SW - DUTY_QBITS));
                    cnt_next = CNTW'(DUTY_QBITS);
                end
                OP_SPEED: begin
                    rem_next = RW'(spd_prod >> SPD_QBITS);
                    den_next = RW'(PCT_SCALE - cfg.start_duty);
                    num_next = SW'({{SW{1'b0}}, spd_prod} << (SW - SPD_QBITS));
                    cnt_next = CNTW'(SPD_QBITS);
                end
                OP_HALF: begin
                    rem_next = RW'(half_num >> HB);
                    den_next = RW'(half_den);
                    num_next = SW'({{SW{1'b0}}, half_num} << (SW - HB));
                    cnt_next = CNTW'(HB);
                end
                default: begin
                    rem_next = '0;
                    den_next = '0;
                    num_next = '0;
                    cnt_next = '0;
                end
            endcase
        end

        if (cmd.step) begin
            rem_next = fits ? trial_diff[RW-1:0] : trial[RW-1:0];
            num_next = num_reg << 1;
            quo_next = {quo_reg[SW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.finish) begin
            case (cmd.op)
                OP_DUTY: begin
                    if (period_reg == '0) begin
                        duty_next = '0;
                    end else if (cmd.ovf || quo_reg > SW'(255)) begin
                        duty_next = '1;
                    end else begin
                        duty_next = quo_reg[DUTY_W-1:0];
                    end
                end
                OP_SPEED: begin
                    rpm_next = cmd.ovf ? '1 : quo_reg[RPM_W-1:0];
                end
                OP_HALF: begin
                    // An overflowed half period lies beyond the counter's reach.
                    if (!cmd.ovf && half_hit) begin
                        tach_cnt_next = '0;
                        tach_out_next = !tach_out_reg;
                    end else begin
                        tach_cnt_next = tach_inc;
                    end
                end
                default: begin
                    duty_next = duty_reg;
                end
            endcase
        end

        if (cmd.spd_zero) begin
            rpm_next = '0;
        end
        if (cmd.spd_max) begin
            rpm_next = cfg.max_rpm;
        end
        if (cmd.tach_clear) begin
            tach_cnt_next = '0;
        end

        if (cmd.out_load) begin
            out_tach_next = tach_out_reg;
            out_rpm_next  = rpm_reg;
            out_duty_next = duty_reg;
        end
    end

    always_comb begin
        status.pre_ovf       = rem_reg >= den_reg;
        status.last_step     = cnt_reg == CNTW'(1);
        status.duty_lt_start = duty_reg < DUTY_W'(cfg.start_duty);
        status.start_ge_100  = cfg.start_duty >= START_LIMIT;
        status.tach_stop     = (rpm_reg == '0) || (cfg.tps == '0) || (cfg.ppr == '0);
    end

    assign out_tach = out_tach_reg;
    assign out_rpm  = out_rpm_reg;
    assign out_duty = out_duty_reg;

endmodule

[src/pwm_fan_tach_model_core.sv]
// PWM fan and tachometer model.
//
// Input channel (s_): one transfer per event. s_tuser[0] is the kind (0 = one machine
// tick, 1 = the pwm pin was written) and s_tdata[0] is the new pin level. Result
// channel (m_): exactly one transfer per input item, carrying the tach level, the
// fan speed in rpm and the measured duty percent after that item.
// Configuration goes through the APB port: ticks per second, maximum rpm, start
// duty and pulses per revolution at byte addresses 0, 4, 8 and 12. Write only
// while no item is in flight.
// Items are handled one at a time by a controller driving one restoring divider
// that resolves a quotient bit per cycle, so the bit counts set the timing. A pwm
// item runs the duty division, cut short after its check when the period is zero
// or the quotient overflows. A tick item runs the speed division unless the speed
// is zero or full, then the half period division of min(COUNT_WIDTH, 38) bits
// unless the tach is stopped. The input opens again in the cycle after the result is written.
// The result sits in an output register; the next item is taken while a result
// still waits, and a stalled receiver holds the block only when a second result
// is ready to be written. A synchronous reset restores the register defaults,
// clears the model counters, the speed and the tach line, and empties the output.
module pwm_fan_tach_model_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pftm_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] pin level, rest zero
    input  logic [0:0]                        s_tuser,   // [0] kind
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pftm_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] tach level, [16:1] rpm,
                                                         // [24:17] duty_percent
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pftm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pftm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pftm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pftm_pkg::*;

    pftm_cfg_t    cfg_reg, cfg_next;
    pftm_cmd_t    cmd;
    pftm_status_t status;
    logic         cfg_wr;
    logic [1:0]   reg_idx;
    logic         out_tach;
    logic [RPM_W-1:0]  out_rpm;
    logic [DUTY_W-1:0] out_duty;

    // Register file. The write lands in the access phase of the transfer.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tps        <= TPS_RESET;
            cfg_reg.max_rpm    <= MAX_RESET;
            cfg_reg.start_duty <= START_RESET;
            cfg_reg.ppr        <= PPR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_TPS:   cfg_next.tps        = pwdata[TPS_W-1:0];
                REG_MAX:   cfg_next.max_rpm    = pwdata[RPM_W-1:0];
                REG_START: cfg_next.start_duty = pwdata[START_W-1:0];
                REG_PPR:   cfg_next.ppr        = pwdata[PPR_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TPS:   prdata = APB_DATA_W'(cfg_reg.tps);
            REG_MAX:   prdata = APB_DATA_W'(cfg_reg.max_rpm);
            REG_START: prdata = APB_DATA_W'(cfg_reg.start_duty);
            REG_PPR:   prdata = APB_DATA_W'(cfg_reg.ppr);
            default:   prdata = '0;
        endcase
    end

    // Sequencer: decides which division runs and when the result is written.
    pftm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Model state, the shared divider and the output register.
    pftm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_kind  (s_tuser[0]),
        .in_level (s_tdata[0]),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .out_tach (out_tach),
        .out_rpm  (out_rpm),
        .out_duty (out_duty)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_duty, out_rpm, out_tach};

    // Only one item is in work at a time, so the input closes right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is still in work");

    // No item completes in the cycle that follows its own transfer.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised directly after an input transfer");

    // An input transfer never coincides with a divider step, a finish or a result write.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !cmd.out_load && !cmd.step && !cmd.finish)
        else $error("input transfer overlaps divider or output work");

endmodule

[bench/pwm_fan_tach_model_core_tb_pkg.sv]
`timescale 1ns / 100ps

package pwm_fan_tach_model_core_tb_pkg;

    import pftm_pkg::*;

    // Kind of an input transfer, carried in s_tuser[0].
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_PWM  = 1'b1
    } fan_kind_t;

    // One result as the result channel reports it.
    typedef struct packed {
        logic              tach;
        logic [RPM_W-1:0]  rpm;
        logic [DUTY_W-1:0] duty_percent;
    } fan_reading_t;

endpackage

[bench/pwm_fan_tach_model_core_check.sv]
`timescale 1ns / 100ps

module pwm_fan_tach_model_core_check #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [pftm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [pftm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [pftm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pftm_pkg::APB_DATA_W-1:0] pwdata,
    output int                              readings_pending,
    output int                              mismatch_count
);

    import pftm_pkg::*;
    import pwm_fan_tach_model_core_tb_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    pftm_cfg_t              fan_cfg;
    logic                   pwm_last;
    logic [COUNT_WIDTH-1:0] ticks_since_rise;
    logic [COUNT_WIDTH-1:0] period_len;
    logic [COUNT_WIDTH-1:0] high_len;
    logic [COUNT_WIDTH-1:0] tach_phase;
    logic [RPM_W-1:0]       fan_rpm;
    logic                   tach_line;

    fan_reading_t           expected_readings[$];
    int                     mismatches = 0;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // High time over period in percent, saturated to eight bits.
    function automatic logic [DUTY_W-1:0] measured_duty();
        logic [63:0] d;
        if (period_len == 0)
            return '0;
        d = (64'(high_len) * 64'd100) / 64'(period_len);
        return (d > 64'd255) ? 8'hFF : d[DUTY_W-1:0];
    endfunction

    function automatic logic [RPM_W-1:0] fan_speed_for(input logic [DUTY_W-1:0] duty);
        logic [63:0] r;
        if (64'(duty) < 64'(fan_cfg.start_duty))
            return '0;
        if (fan_cfg.start_duty >= 7'd100)
            return fan_cfg.max_rpm;
        r = 64'(fan_cfg.max_rpm) * (64'(duty) - 64'(fan_cfg.start_duty))
            / (64'd100 - 64'(fan_cfg.start_duty));
        return (r > 64'd65535) ? 16'hFFFF : r[RPM_W-1:0];
    endfunction

    // Applies one input event to the predicted fan and returns what the block reports.
    function automatic fan_reading_t apply_event(input fan_kind_t kind, input logic level);
        fan_reading_t rd;
        logic [63:0]  half;
        if (kind == KIND_PWM) begin
            if (level && !pwm_last) begin
                if (ticks_since_rise != 0)
                    period_len = ticks_since_rise;
                ticks_since_rise = '0;
            end else if (!level && pwm_last) begin
                high_len = ticks_since_rise;
            end
            pwm_last = level;
        end else begin
            ticks_since_rise = bump(ticks_since_rise);
            fan_rpm = fan_speed_for(measured_duty());
            if (fan_rpm == 0 || fan_cfg.tps == 0 || fan_cfg.ppr == 0) begin
                tach_phase = '0;
            end else begin
                half = (64'(fan_cfg.tps) * 64'd60)
                       / (64'(fan_rpm) * 64'(fan_cfg.ppr) * 64'd2);
                if (half == 0)
                    half = 64'd1;
                tach_phase = bump(tach_phase);
                if (64'(tach_phase) >= half) begin
                    tach_phase = '0;
                    tach_line  = ~tach_line;
                end
            end
        end
        rd.tach         = tach_line;
        rd.rpm          = fan_rpm;
        rd.duty_percent = measured_duty();
        return rd;
    endfunction

    always @(posedge aclk) begin
        fan_reading_t want;
        fan_reading_t got;
        if (!aresetn) begin
            fan_cfg.tps        = TPS_RESET;
            fan_cfg.max_rpm    = MAX_RESET;
            fan_cfg.start_duty = START_RESET;
            fan_cfg.ppr        = PPR_RESET;
            pwm_last           = 1'b0;
            ticks_since_rise   = '0;
            period_len         = '0;
            high_len           = '0;
            tach_phase         = '0;
            fan_rpm            = '0;
            tach_line          = 1'b0;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TPS:   fan_cfg.tps        = pwdata[TPS_W-1:0];
                    REG_MAX:   fan_cfg.max_rpm    = pwdata[RPM_W-1:0];
                    REG_START: fan_cfg.start_duty = pwdata[START_W-1:0];
                    REG_PPR:   fan_cfg.ppr        = pwdata[PPR_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(apply_event(fan_kind_t'(s_tuser[0]), s_tdata[0]));
            if (m_tvalid && m_tready) begin
                got.tach         = m_tdata[0];
                got.rpm          = m_tdata[16:1];
                got.duty_percent = m_tdata[24:17];
                if (expected_readings.size() == 0) begin
                    $error("result transfer with no reading expected (m_tdata %h)", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.tach !== want.tach) begin
                        $error("tach: expected %0d, actual %0d",
                               want.tach, got.tach);
                        mismatches++;
                    end
                    if (got.rpm !== want.rpm) begin
                        $error("rpm: expected %0d, actual %0d", want.rpm, got.rpm);
                        mismatches++;
                    end
                    if (got.duty_percent !== want.duty_percent) begin
                        $error("duty_percent: expected %0d, actual %0d",
                               want.duty_percent, got.duty_percent);
                        mismatches++;
                    end
                end
            end
        end
        readings_pending <= expected_readings.size();
        mismatch_count   <= mismatches;
    end

endmodule

[bench/pwm_fan_tach_model_core_test.sv]
`timescale 1ns / 100ps

module pwm_fan_tach_model_core_test;

    import pftm_pkg::*;
    import pwm_fan_tach_model_core_tb_pkg::*;

    // A run ends in failure once this many cycles go by without any transfer.
    localparam int QUIET_LIMIT  = 3000;
    // Length of the deliberate sink hold-off, in cycles.
    localparam int HOLD_CYCLES  = 400;
    // Random items per register setting; four idle profiles of three settings each.
    localparam int ITEMS_PER_SET = 155;

    logic                    aclk;
    logic                    aresetn = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;   // [0] pin level, rest zero
    logic [0:0]              s_tuser  = '0;   // [0] kind
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;         // [0] tach level, [16:1] rpm, [24:17] duty
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int                      readings_pending;
    int                      mismatch_count;

    // Idle percentages of the two sides; the stimulus process changes them per phase.
    int                      src_idle_pct = 0;
    int                      snk_stall_pct = 0;
    // Hold-offs asked for by the stimulus and hold-offs already served by the sink.
    int                      holds_asked = 0;
    int                      holds_served = 0;

    int                      items_sent = 0;
    int                      reg_writes = 0;
    int                      results_seen = 0;
    int                      quiet_cycles = 0;

    pwm_fan_tach_model_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The checker watches every channel, predicts each result and counts mismatches.
    pwm_fan_tach_model_core_check tach_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .readings_pending (readings_pending),
        .mismatch_count   (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Reset is held at the start and never asserted again.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Sink side. Normally it stalls at random with the current percentage. When the
    // stimulus asks for a hold-off, it keeps tready low for a long stretch counted
    // here, so the output register fills and the block pushes back on its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != holds_asked) begin
                holds_served <= holds_asked;
                m_tready     <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Watchdog: any transfer on either stream or the register port restarts the count.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready && aresetn)
            results_seen <= results_seen + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one event and returns at the edge where it is transferred. A random
    // gap before the offer drops tvalid; otherwise tvalid stays high back to back.
    task automatic send_event(input fan_kind_t kind, input logic level);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, level};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_event(KIND_TICK, 1'($urandom_range(1)));
    endtask

    // Stops offering and waits until every predicted reading has come back, then keeps
    // waiting so the controller is surely back in its idle state. The pending count
    // is registered, hence the edge before the first look.
    task automatic wait_all_readings();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings_pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. The trailing edge
    // keeps the next write's setup out of this time step.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    task automatic write_settings(input logic [TPS_W-1:0] tps, input logic [RPM_W-1:0] top_rpm,
                                  input logic [START_W-1:0] start, input logic [PPR_W-1:0] ppr);
        write_reg(REG_TPS, 32'(tps));
        write_reg(REG_MAX, 32'(top_rpm));
        write_reg(REG_START, 32'(start));
        write_reg(REG_PPR, 32'(ppr));
    endtask

    // Mostly settings where the tach half period is a handful of ticks, so the
    // tach line actually toggles; now and then the extremes of every register,
    // including a start threshold of 100 or more and zero pulses per revolution.
    task automatic pick_settings();
        logic [TPS_W-1:0]   tps;
        logic [RPM_W-1:0]   top_rpm;
        logic [START_W-1:0] start;
        logic [PPR_W-1:0]   ppr;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: tps = $urandom_range(1, 5000);
            6:                tps = $urandom;
            7:                tps = '0;
            8:                tps = '1;
            default:          tps = $urandom_range(5000, 200000);
        endcase
        case ($urandom_range(9))
            7:       top_rpm = '0;
            8:       top_rpm = '1;
            9:       top_rpm = RPM_W'($urandom_range(0, 65535));
            default: top_rpm = RPM_W'($urandom_range(500, 12000));
        endcase
        case ($urandom_range(9))
            6:       start = '0;
            7:       start = 7'd99;
            8:       start = START_W'($urandom_range(100, 127));
            9:       start = START_W'($urandom_range(61, 99));
            default: start = START_W'($urandom_range(0, 60));
        endcase
        case ($urandom_range(9))
            8:       ppr = '0;
            9:       ppr = PPR_W'($urandom_range(9, 15));
            default: ppr = PPR_W'($urandom_range(1, 8));
        endcase
        write_settings(tps, top_rpm, start, ppr);
    endtask

    // One well-formed pwm period: rise, high ticks, fall, low ticks. Now and then a
    // write of an unchanged level is slipped in; a long high phase after a short
    // period drives the duty above 100 and into saturation.
    task automatic pwm_period();
        int high_ticks_n;
        int low_ticks_n;
        high_ticks_n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        low_ticks_n  = $urandom_range(0, 12);
        send_event(KIND_PWM, 1'b1);
        if ($urandom_range(9) == 0)
            send_event(KIND_PWM, 1'b1);
        send_ticks(high_ticks_n);
        send_event(KIND_PWM, 1'b0);
        if ($urandom_range(9) == 0)
            send_event(KIND_PWM, 1'b0);
        send_ticks(low_ticks_n);
    endtask

    task automatic random_events(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                pwm_period();
            end else begin
                // Noise: a short burst of events of any kind and level.
                repeat ($urandom_range(1, 4))
                    send_event(fan_kind_t'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        int profile;
        int setting;
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // Directed part under the reset settings: ticks, a write that keeps the level,
        // a rise after two ticks, a short period with a long high time (duty of 150),
        // a rise one tick after the fall, a fall right after that rise (zero high time)
        // and a rise with no ticks since the last one, which must not latch a period.
        send_event(KIND_TICK, 1'b0);
        send_event(KIND_PWM, 1'b0);
        send_event(KIND_TICK, 1'b1);
        send_event(KIND_PWM, 1'b1);
        send_event(KIND_PWM, 1'b1);
        send_ticks(3);
        send_event(KIND_PWM, 1'b0);
        send_event(KIND_TICK, 1'b0);
        send_event(KIND_PWM, 1'b1);
        send_event(KIND_PWM, 1'b0);
        send_event(KIND_PWM, 1'b1);
        send_event(KIND_TICK, 1'b1);

        // Full scale speed with no start threshold: a long high time over the four-tick
        // period gives a duty of 150, which overflows the speed, and the half period
        // rounds to zero, so the tach toggles each tick.
        wait_all_readings();
        write_settings(32'd60, 16'hFFFF, 7'd0, 4'd1);
        send_ticks(5);
        send_event(KIND_PWM, 1'b0);
        send_ticks(3);

        // Start thresholds at and above 100, zero and maximum pulses per revolution,
        // a stopped tick rate, and the largest tick rate with zero maximum speed.
        wait_all_readings();
        write_settings(32'd60, 16'hFFFF, 7'd127, 4'd1);
        send_ticks(1);
        wait_all_readings();
        write_settings(32'd60, 16'hFFFF, 7'd100, 4'd1);
        send_ticks(1);
        wait_all_readings();
        write_settings(32'd60, 16'd1000, 7'd0, 4'd0);
        send_ticks(1);
        wait_all_readings();
        write_settings(32'd0, 16'd1000, 7'd0, 4'd15);
        send_ticks(1);
        wait_all_readings();
        write_settings(32'hFFFF_FFFF, 16'd0, 7'd99, 4'd8);
        send_ticks(1);

        // Random part: four idle profiles, three register settings in each.
        for (profile = 0; profile < 4; profile++) begin
            case (profile)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 78; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 78; end
                default: begin src_idle_pct = 11; snk_stall_pct = 11; end
            endcase
            for (setting = 0; setting < 3; setting++) begin
                wait_all_readings();
                pick_settings();
                if (profile == 0 && setting == 1) begin
                    // Long sink hold-off while the source keeps offering.
                    holds_asked <= holds_asked + 1;
                end
                if (profile == 1 && setting == 0) begin
                    // Pause the source mid-run until every reading is back.
                    random_events(ITEMS_PER_SET / 2);
                    wait_all_readings();
                    random_events(ITEMS_PER_SET - ITEMS_PER_SET / 2);
                end else begin
                    random_events(ITEMS_PER_SET);
                end
            end
        end

        wait_all_readings();
        repeat (70) @(posedge aclk);

        $display("Covered %0d tick and pwm events over %0d register writes, four idle profiles,",
                 items_sent, reg_writes);
        $display("a long sink hold-off and a mid-run drain; %0d results were compared.",
                 results_seen);
        if (mismatch_count == 0 && readings_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
